[hdl/threshold_filter_rank_buffer_assert.svh]
// Assertion macros for the threshold filter rank buffer.
`ifndef THRESHOLD_FILTER_RANK_BUFFER_ASSERT_SVH
`define THRESHOLD_FILTER_RANK_BUFFER_ASSERT_SVH
`ifndef SYNTH
`define TFRB_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define TFRB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TFRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TFRB_ASSERT(lbl, cond)
`define TFRB_ASSERT_IMP(lbl, ante, cons)
`define TFRB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/tfrb_pkg.sv]
// Shared constants, codes and controller/datapath types for the rank buffer.
package tfrb_pkg;

    localparam int CAPACITY     = 256;
    localparam int FILE_ID_BITS = 16;
    localparam int SCORE_W      = 16;
    localparam int FID_IN_W     = 16;
    localparam int RANK_W       = 8;
    localparam int KEPT_W       = 9;
    localparam int KEPT_MAX     = 511;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int ENTRY_W      = SCORE_W + FILE_ID_BITS;
    localparam logic signed [SCORE_W-1:0] THRESH_RESET = 16'sd4096;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_OFFER = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SHIFT,
        S_PLACE,
        S_READ,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_RANK,
        RD_J1,
        RD_J2
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    clear;
        rd_sel_t rd_sel;
        logic    shift;
        logic    place;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic qual;
        logic rd_ok;
        logic j_zero;
        logic j_one;
        logic greater;
        logic out_free;
    } dp_status_t;

endpackage

[hdl/tfrb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tfrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/tfrb_ctrl.sv]
// Controller state machine: sequences accept, insertion walk, read and delivery.
module tfrb_ctrl
    import tfrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] command,
    input  dp_status_t status,
    output logic       in_stall,
    output ctrl_cmd_t  ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_stall      = 1'b1;
        ctrl          = '0;
        ctrl.rd_sel   = RD_RANK;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    unique case (cmd_t'(command))
                        CMD_CLEAR:
                        begin
                            ctrl.clear = 1'b1;
                            state_next = S_DONE;
                        end
                        CMD_OFFER: state_next = status.qual ? S_FETCH : S_DONE;
                        CMD_READ:  state_next = status.rd_ok ? S_READ : S_DONE;
                        CMD_NOP:   state_next = S_DONE;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_FETCH:
            begin
                ctrl.rd_sel = RD_J1;
                state_next  = status.j_zero ? S_PLACE : S_SHIFT;
            end
            S_SHIFT:
            begin
                if (status.greater)
                begin
                    ctrl.shift  = 1'b1;
                    ctrl.rd_sel = RD_J2;
                    state_next  = status.j_one ? S_PLACE : S_SHIFT;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                ctrl.place = 1'b1;
                state_next = S_DONE;
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/tfrb_datapath.sv]
// Datapath: item registers, ranked store, list count, threshold and result register.
module tfrb_datapath
    import tfrb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 command,
    input  logic [FID_IN_W-1:0]        file_id,
    input  logic signed [SCORE_W-1:0]  score,
    input  logic [RANK_W-1:0]          read_rank,
    input  logic                       score_threshold_we,
    input  logic signed [SCORE_W-1:0]  score_threshold,
    input  ctrl_cmd_t                  ctrl,
    output dp_status_t                 status,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic [KEPT_W-1:0]          kept_count,
    output logic                       accepted,
    output logic                       entry_valid,
    output logic [FID_IN_W-1:0]        entry_file_id,
    output logic signed [SCORE_W-1:0]  entry_score
);

    logic signed [SCORE_W-1:0] thr_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          j_reg;
    cmd_t                      cmd_reg;
    logic                      hit_reg;
    logic [FILE_ID_BITS-1:0]   fid_reg;
    logic signed [SCORE_W-1:0] sc_reg;
    logic [RANK_W-1:0]         rank_reg;
    logic                      out_valid_reg;
    logic [KEPT_W-1:0]         kept_reg;
    logic                      acc_reg;
    logic                      ev_reg;
    logic [FID_IN_W-1:0]       efid_reg;
    logic signed [SCORE_W-1:0] esc_reg;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]          ram_raddr;
    logic [ENTRY_W-1:0]        ram_rdata;
    logic signed [SCORE_W-1:0] rd_score;
    logic [FILE_ID_BITS-1:0]   rd_fid;
    logic                      ev_next;

    assign rd_score = ram_rdata[ENTRY_W-1:FILE_ID_BITS];
    assign rd_fid   = ram_rdata[FILE_ID_BITS-1:0];

    always_comb
    begin
        unique case (ctrl.rd_sel)
            RD_J1:   ram_raddr = IDX_W'(j_reg - CNT_W'(1));
            RD_J2:   ram_raddr = IDX_W'(j_reg - CNT_W'(2));
            RD_RANK: ram_raddr = IDX_W'(rank_reg);
            default: ram_raddr = IDX_W'(rank_reg);
        endcase
    end

    assign ram_we    = ctrl.shift | ctrl.place;
    assign ram_waddr = IDX_W'(j_reg);
    assign ram_wdata = ctrl.shift ? ram_rdata : {sc_reg, fid_reg};

    tfrb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.qual     = (count_reg < CNT_W'(CAPACITY)) && (score < thr_reg);
    assign status.rd_ok    = read_rank < count_reg;
    assign status.j_zero   = j_reg == '0;
    assign status.j_one    = j_reg == CNT_W'(1);
    assign status.greater  = rd_score > sc_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESH_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (score_threshold_we)
            begin
                thr_reg <= score_threshold;
            end
            if (ctrl.clear)
            begin
                count_reg <= '0;
            end
            else if (ctrl.place)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign ev_next = (cmd_reg == CMD_READ) && hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= cmd_t'(command);
            fid_reg  <= FILE_ID_BITS'(file_id);
            sc_reg   <= score;
            rank_reg <= read_rank;
            j_reg    <= count_reg;
            hit_reg  <= (cmd_t'(command) == CMD_OFFER) ? status.qual : status.rd_ok;
        end
        else if (ctrl.shift)
        begin
            j_reg <= j_reg - CNT_W'(1);
        end
        if (ctrl.out_load)
        begin
            kept_reg <= (count_reg > KEPT_MAX) ? KEPT_W'(KEPT_MAX) : KEPT_W'(count_reg);
            acc_reg  <= (cmd_reg == CMD_OFFER) && hit_reg;
            ev_reg   <= ev_next;
            efid_reg <= ev_next ? FID_IN_W'(rd_fid) : '0;
            esc_reg  <= ev_next ? rd_score : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kept_count    = kept_reg;
    assign accepted      = acc_reg;
    assign entry_valid   = ev_reg;
    assign entry_file_id = efid_reg;
    assign entry_score   = esc_reg;

endmodule

[hdl/threshold_filter_rank_buffer.sv]
// Top level of the threshold filter rank buffer: controller, datapath and checks.
//
// channel   direction  handshake            word
// in        to block   in_valid / in_stall   command, file_id, score, read_rank
// out       from block out_valid / out_stall kept_count, accepted, entry_valid,
//                                             entry_file_id, entry_score
// cfg       to block   score_threshold_we    score_threshold
//
// Clear, no-op, a rejected offer and an out-of-range read go straight to delivery;
// an in-range read first reads the store RAM. An accepted offer walks down the store RAM one entry
// a cycle, moving each larger entry up one place, then writes the new item into the gap.
// Reset empties the list and loads the threshold with 4096; the store is not swept.
// in_stall is high from acceptance until the result enters the output register,
// which holds its word while out_stall is high.
module threshold_filter_rank_buffer
    import tfrb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 command,
    input  logic [FID_IN_W-1:0]        file_id,
    input  logic signed [SCORE_W-1:0]  score,
    input  logic [RANK_W-1:0]          read_rank,
    input  logic                       score_threshold_we,
    input  logic signed [SCORE_W-1:0]  score_threshold,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [KEPT_W-1:0]          kept_count,
    output logic                       accepted,
    output logic                       entry_valid,
    output logic [FID_IN_W-1:0]        entry_file_id,
    output logic signed [SCORE_W-1:0]  entry_score
);

`include "threshold_filter_rank_buffer_assert.svh"

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    tfrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .status   (status),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    tfrb_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .command            (command),
        .file_id            (file_id),
        .score              (score),
        .read_rank          (read_rank),
        .score_threshold_we (score_threshold_we),
        .score_threshold    (score_threshold),
        .ctrl               (ctrl),
        .status             (status),
        .out_stall          (out_stall),
        .out_valid          (out_valid),
        .kept_count         (kept_count),
        .accepted           (accepted),
        .entry_valid        (entry_valid),
        .entry_file_id      (entry_file_id),
        .entry_score        (entry_score)
    );

    `TFRB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `TFRB_ASSERT_IMP(a_one_kind, out_valid, !(accepted && entry_valid))
    `TFRB_ASSERT_IMP(a_invalid_zero, out_valid && !entry_valid, {entry_file_id, entry_score} == '0)
    `TFRB_ASSERT_IMP(a_count_bound, out_valid, kept_count <= CAPACITY)
    `TFRB_ASSERT(a_single_write, !(ctrl.shift && ctrl.place))

endmodule
